// ----- src/fpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsd_pkg
// Shared types and constants of the frame pacing skip decider.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsd_pkg;

  localparam int STEP_W = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_RR_MUL,
    S_RR_DIV,
    S_SR_MUL,
    S_SR_DIV,
    S_LD_DMUL,
    S_LD_NMUL,
    S_LD_DIV,
    S_CLEAR,
    S_T_SPAN,
    S_T_IDLE,
    S_T_SCHED,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DEC_IDLE   = 2'd0,
    DEC_RENDER = 2'd1,
    DEC_SKIP   = 2'd2
  } dec_t;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic              start;
    mdu_op_t           op;
    logic [STEP_W-1:0] steps;
  } mdu_req_t;

  typedef struct packed {
    logic done;
    logic num_zero;
  } mdu_sts_t;

  // register map, word index
  localparam logic [2:0] REG_TPS    = 3'd0;
  localparam logic [2:0] REG_TR     = 3'd1;
  localparam logic [2:0] REG_WF     = 3'd2;
  localparam logic [2:0] REG_MARGIN = 3'd3;
  localparam logic [2:0] REG_MCS    = 3'd4;

  localparam logic [31:0] TPS_RST    = 32'd1000000;
  localparam logic [9:0]  TR_RST     = 10'd60;
  localparam logic [7:0]  WF_RST     = 8'd60;
  localparam logic [3:0]  MARGIN_RST = 4'd2;
  localparam logic [2:0]  MCS_RST    = 3'd1;

  localparam logic [18:0] LOAD_ONE = 19'd65536;
  localparam logic [18:0] LOAD_MAX = 19'd262144;
  localparam logic [15:0] RATE_MAX = 16'hFFFF;

  // (1.1 / 2) scaled by 1310720
  localparam logic [30:0] THR_BIAS = 31'd720896;

  // serial step counts
  localparam logic [STEP_W-1:0] CNT_STEPS   = 5'd8;
  localparam logic [STEP_W-1:0] TR_STEPS    = 5'd10;
  localparam logic [STEP_W-1:0] TH_STEPS    = 5'd29;
  localparam logic [STEP_W-1:0] SCHED_STEPS = 5'd10;
  localparam logic [STEP_W-1:0] RATE_STEPS  = 5'd17;
  localparam logic [STEP_W-1:0] LOAD_STEPS  = 5'd19;

endpackage

`default_nettype wire

// ----- src/fpsd_mdu.sv -----
// ----------------------------------------------------------------------------
// fpsd_mdu
// Bit-serial multiply / divide unit: shift-add multiply, one multiplier bit
// per cycle, and restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsd_mdu
  import fpsd_pkg::*;
#(
  parameter int XW = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  mdu_req_t      req,
  input  logic [XW-1:0] opa,
  input  logic [XW-1:0] opb,
  output mdu_sts_t      sts,
  output logic [XW-1:0] res
);

  logic [XW-1:0]     x;
  logic [XW-1:0]     y;
  logic [XW-1:0]     z;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic              num_zero;
  mdu_op_t           op;
  logic [XW-1:0]     sum;
  logic [XW-1:0]     dif;
  logic              borrow;

  assign sum = z + x;
  assign {borrow, dif} = {1'b0, x} - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op       <= req.op;
      x        <= opa;
      y        <= opb;
      z        <= '0;
      num_zero <= (opa == '0);
    end else if (busy) begin
      case (op)
        MDU_MUL: begin
          if (y[0]) z <= sum;
          x <= x << 1;
          y <= y >> 1;
        end
        MDU_DIV: begin
          if (!borrow) begin
            x <= dif;
            z <= {z[XW-2:0], 1'b1};
          end else begin
            z <= {z[XW-2:0], 1'b0};
          end
          y <= y >> 1;
        end
        default: ;
      endcase
    end
  end

  assign sts.done     = done;
  assign sts.num_zero = num_zero;
  assign res          = z;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("mdu started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("mdu done held longer than one cycle");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == STEP_W'(1)) |=> (done && !busy))
    else $error("mdu missed its last step");

endmodule

`default_nettype wire

// ----- src/frame_pacing_skip_decider_core.sv -----
// ----------------------------------------------------------------------------
// frame_pacing_skip_decider_core
// Per-frame pacing decision (idle, render, skip) with windowed render/skip
// rates and load, computed on a shared bit-serial multiply/divide unit.
//
//   channel  signals                          word
//   -------  -------------------------------  ---------------------------------
//   in       in_valid / in_ready              now_ticks
//   out      out_valid / out_ready            decision, load_q16, rates
//   cfg      psel penable pwrite paddr ...    5 registers at 4*i, pready = 1
//
// On a window boundary the rates and load are also computed, unless time went
// backward; all serial ops run one after another on the shared unit.
// One item in flight; the next word is taken while the result waits in the
// output register, which only stalls the end of the following item.
// Synchronous reset: window starts at time 0, load 1.0, rates 0.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_skip_decider_core
  import fpsd_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] now_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            decision,
  output logic [18:0]           load_q16,
  output logic [15:0]           render_rate_q8,
  output logic [15:0]           skip_rate_q8,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int W  = TIME_WIDTH;
  localparam int XW = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 32;

  // configuration
  logic [31:0] tps;
  logic [9:0]  tr;
  logic [7:0]  wf;
  logic [3:0]  margin;
  logic [2:0]  mcs;

  // block state
  logic [W-1:0] window_start;
  logic [W-1:0] prev_time;
  logic [W-1:0] busy_time;
  logic [7:0]   rendered;
  logic [7:0]   skipped;
  logic [2:0]   skips_in_row;
  dec_t         last_dec;
  logic [18:0]  load_value;
  logic [15:0]  rr_held;
  logic [15:0]  sr_held;

  // sequencer
  state_t state;
  state_t state_next;
  logic   launched;
  logic   launched_next;
  dec_t   dec_r;
  dec_t   dec_next;
  logic   is_op;
  logic   out_load;

  // per-item work registers
  logic [W-1:0]  now_r;
  logic [W-1:0]  diff_r;
  logic [W-1:0]  span_r;
  logic [W-1:0]  busy_load;
  logic          span_zero;
  logic [8:0]    total_r;
  logic [XW-1:0] tmp_r;
  logic [XW-1:0] c_r;
  logic [XW-1:0] a_r;

  // shared serial unit
  mdu_req_t      mdu_req;
  mdu_sts_t      mdu_sts;
  logic [XW-1:0] mdu_a;
  logic [XW-1:0] mdu_b;
  logic [XW-1:0] mdu_res;

  logic          cfg_wr;
  logic          neg;
  logic [W-1:0]  span_mag;
  logic [8:0]    total;
  logic          recomp;
  logic          force_render;
  logic [30:0]   thresh;
  logic          thresh_pos;
  logic [15:0]   rate_sat;
  logic [18:0]   load_sat;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  assign neg          = diff_r[W-1];
  assign span_mag     = neg ? ((~diff_r) + W'(1)) : diff_r;
  assign total        = 9'(rendered) + 9'(skipped);
  assign recomp       = (total >= 9'(wf));
  assign force_render = (skips_in_row >= mcs);

  // r*1310720 + 720896 - 10*load, two's complement
  assign thresh = 31'({rendered, 20'b0}) + 31'({rendered, 18'b0}) + THR_BIAS
                - 31'({load_value, 3'b0}) - 31'({load_value, 1'b0});
  assign thresh_pos = !thresh[30] && (thresh != '0);

  assign rate_sat = mdu_sts.num_zero ? '0 :
                    (mdu_res[16] ? RATE_MAX : mdu_res[15:0]);
  assign load_sat = mdu_sts.num_zero ? '0 :
                    (mdu_res[18] ? LOAD_MAX : {1'b0, mdu_res[17:0]});

  always_comb begin
    case (paddr[4:2])
      REG_TPS:    prdata = tps;
      REG_TR:     prdata = 32'(tr);
      REG_WF:     prdata = 32'(wf);
      REG_MARGIN: prdata = 32'(margin);
      REG_MCS:    prdata = 32'(mcs);
      default:    prdata = '0;
    endcase
  end

  fpsd_mdu #(
    .XW (XW)
  ) u_mdu (
    .clk (clk),
    .rst (rst),
    .req (mdu_req),
    .opa (mdu_a),
    .opb (mdu_b),
    .sts (mdu_sts),
    .res (mdu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    dec_next      = dec_r;
    is_op         = 1'b0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    mdu_req.op    = MDU_MUL;
    mdu_req.steps = '0;
    mdu_a         = '0;
    mdu_b         = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (recomp) state_next = neg ? S_CLEAR : S_RR_MUL;
        else state_next = S_T_SPAN;
      end
      S_RR_MUL: begin
        is_op         = 1'b1;
        mdu_req.steps = CNT_STEPS;
        mdu_a         = XW'(tps);
        mdu_b         = XW'(rendered);
        if (mdu_sts.done) state_next = S_RR_DIV;
      end
      S_RR_DIV: begin
        is_op         = 1'b1;
        mdu_req.op    = MDU_DIV;
        mdu_req.steps = RATE_STEPS;
        mdu_a         = mdu_res << 8;
        mdu_b         = XW'(span_r) << 16;
        if (mdu_sts.done) state_next = S_SR_MUL;
      end
      S_SR_MUL: begin
        is_op         = 1'b1;
        mdu_req.steps = CNT_STEPS;
        mdu_a         = XW'(tps);
        mdu_b         = XW'(skipped);
        if (mdu_sts.done) state_next = S_SR_DIV;
      end
      S_SR_DIV: begin
        is_op         = 1'b1;
        mdu_req.op    = MDU_DIV;
        mdu_req.steps = RATE_STEPS;
        mdu_a         = mdu_res << 8;
        mdu_b         = XW'(span_r) << 16;
        if (mdu_sts.done) state_next = (rendered != '0) ? S_LD_DMUL : S_CLEAR;
      end
      S_LD_DMUL: begin
        is_op         = 1'b1;
        mdu_req.steps = CNT_STEPS;
        mdu_a         = XW'(span_r);
        mdu_b         = XW'(rendered);
        if (mdu_sts.done) state_next = S_LD_NMUL;
      end
      S_LD_NMUL: begin
        is_op         = 1'b1;
        mdu_req.steps = TR_STEPS;
        mdu_a         = XW'(busy_load);
        mdu_b         = XW'(tr);
        if (mdu_sts.done) state_next = S_LD_DIV;
      end
      S_LD_DIV: begin
        is_op         = 1'b1;
        mdu_req.op    = MDU_DIV;
        mdu_req.steps = LOAD_STEPS;
        mdu_a         = mdu_res << 16;
        mdu_b         = tmp_r << 18;
        if (mdu_sts.done) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        state_next = S_T_SPAN;
      end
      S_T_SPAN: begin
        is_op         = 1'b1;
        mdu_req.steps = TR_STEPS;
        mdu_a         = span_zero ? '0 : XW'(span_r);
        mdu_b         = XW'(tr);
        if (mdu_sts.done) begin
          if (thresh_pos) begin
            state_next = S_T_IDLE;
          end else if (force_render) begin
            dec_next   = DEC_RENDER;
            state_next = S_DECIDE;
          end else begin
            state_next = S_T_SCHED;
          end
        end
      end
      S_T_IDLE: begin
        is_op         = 1'b1;
        mdu_req.steps = TH_STEPS;
        mdu_a         = XW'(tps);
        mdu_b         = XW'(thresh[28:0]);
        if (mdu_sts.done) begin
          if (a_r < mdu_res) begin
            dec_next   = DEC_IDLE;
            state_next = S_DECIDE;
          end else if (force_render) begin
            dec_next   = DEC_RENDER;
            state_next = S_DECIDE;
          end else begin
            state_next = S_T_SCHED;
          end
        end
      end
      S_T_SCHED: begin
        is_op         = 1'b1;
        mdu_req.steps = SCHED_STEPS;
        mdu_a         = XW'(tps);
        mdu_b         = XW'(total_r) + XW'(margin);
        if (mdu_sts.done) begin
          dec_next   = (c_r < mdu_res) ? DEC_RENDER : DEC_SKIP;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    mdu_req.start = is_op && !launched;
    if (mdu_req.start) launched_next = 1'b1;
    if (mdu_sts.done) launched_next = 1'b0;
  end

  // block state, configuration, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tps          <= TPS_RST;
      tr           <= TR_RST;
      wf           <= WF_RST;
      margin       <= MARGIN_RST;
      mcs          <= MCS_RST;
      window_start <= '0;
      prev_time    <= '0;
      busy_time    <= '0;
      rendered     <= '0;
      skipped      <= '0;
      skips_in_row <= '0;
      last_dec     <= DEC_IDLE;
      load_value   <= LOAD_ONE;
      rr_held      <= '0;
      sr_held      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_TPS:    tps    <= pwdata;
          REG_TR:     tr     <= pwdata[9:0];
          REG_WF:     wf     <= pwdata[7:0];
          REG_MARGIN: margin <= pwdata[3:0];
          REG_MCS:    mcs    <= pwdata[2:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (last_dec != DEC_IDLE)) begin
            busy_time <= busy_time + now_ticks - prev_time;
          end
        end
        S_EVAL: begin
          prev_time <= now_r;
          if (recomp && neg) begin
            rr_held <= '0;
            sr_held <= '0;
            if (rendered != '0) load_value <= '0;
          end else if (!recomp && neg) begin
            window_start <= now_r;
          end
        end
        S_RR_DIV: if (mdu_sts.done) rr_held <= rate_sat;
        S_SR_DIV: if (mdu_sts.done) sr_held <= rate_sat;
        S_LD_DIV: if (mdu_sts.done) load_value <= load_sat;
        S_CLEAR: begin
          window_start <= now_r;
          rendered     <= '0;
          skipped      <= '0;
          busy_time    <= '0;
        end
        S_DECIDE: begin
          last_dec <= dec_r;
          case (dec_r)
            DEC_RENDER: begin
              if (rendered != 8'hFF) rendered <= rendered + 8'd1;
              skips_in_row <= '0;
            end
            DEC_SKIP: begin
              if (skips_in_row != 3'd7) skips_in_row <= skips_in_row + 3'd1;
              if (skipped != 8'hFF) skipped <= skipped + 8'd1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // per-item work and output word
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          now_r  <= now_ticks;
          diff_r <= now_ticks - window_start;
        end
      end
      S_EVAL: begin
        span_r    <= span_mag;
        span_zero <= recomp || neg;
        total_r   <= total;
        busy_load <= busy_time[W-1] ? '0 : busy_time;
      end
      S_LD_DMUL: if (mdu_sts.done) tmp_r <= mdu_res;
      S_T_SPAN: begin
        if (mdu_sts.done) begin
          c_r <= mdu_res;
          a_r <= (mdu_res << 20) + (mdu_res << 18);
        end
      end
      default: ;
    endcase
    dec_r <= dec_next;
    if (out_load) begin
      decision       <= dec_r;
      load_q16       <= load_value;
      render_rate_q8 <= rr_held;
      skip_rate_q8   <= sr_held;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_value <= LOAD_MAX)
    else $error("load above saturation limit");

  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    mdu_sts.done |-> launched)
    else $error("serial unit finished an op that was never launched");

endmodule

`default_nettype wire

// ----- sim/frame_pacing_skip_decider_core_tb.sv -----
// ----------------------------------------------------------------------------
// frame_pacing_skip_decider_core_tb
// Self-checking bench for the frame pacing skip decider. A queue of frame
// timestamps feeds a valid/ready driver with random gaps. Each accepted word
// is run through a bit-exact pacing model that queues the expected decision,
// load and rates. A monitor with random and long back-pressure compares each
// result word field by field. Register settings change over the run through
// the APB port, only while the block is idle.
// ----------------------------------------------------------------------------
module frame_pacing_skip_decider_core_tb;
  import fpsd_pkg::*;

  localparam int HOLD_CYCLES = 1500;

  typedef struct packed {
    dec_t        decision;
    logic [18:0] load;
    logic [15:0] render_rate;
    logic [15:0] skip_rate;
  } frame_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] now_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  decision;
  logic [18:0] load_q16;
  logic [15:0] render_rate_q8;
  logic [15:0] skip_rate_q8;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        calm = 1'b0;
  logic        send_pause = 1'b0;
  logic        hold_go = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;
  int          errors = 0;

  logic [47:0] frame_ticks[$];
  frame_res_t  pending_decisions[$];
  logic [47:0] tick_clock = '0;

  // register copy
  logic [31:0] cfg_tps = TPS_RST;
  logic [9:0]  cfg_tr = TR_RST;
  logic [7:0]  cfg_wf = WF_RST;
  logic [3:0]  cfg_margin = MARGIN_RST;
  logic [2:0]  cfg_mcs = MCS_RST;

  // pacing state
  logic [47:0] win_start = '0;
  logic [47:0] prev_t = '0;
  logic [47:0] busy_t = '0;
  logic [7:0]  n_rend = '0;
  logic [7:0]  n_skip = '0;
  logic [2:0]  skip_run = '0;
  dec_t        last_dec = DEC_IDLE;
  logic [18:0] load_v = LOAD_ONE;
  logic [15:0] rrate = '0;
  logic [15:0] srate = '0;

  frame_pacing_skip_decider_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .now_ticks      (now_ticks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decision       (decision),
    .load_q16       (load_q16),
    .render_rate_q8 (render_rate_q8),
    .skip_rate_q8   (skip_rate_q8),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // truncating divide, saturating at lim once the quotient reaches 2^shift
  function automatic logic [18:0] sat_div(input logic [127:0] num, input logic [127:0] den,
                                          input int shift, input logic [18:0] lim);
    logic [127:0] q;
    if (den == 0) return (num != 0) ? lim : 19'd0;
    q = num / den;
    if (q >= (128'd1 << shift)) return lim;
    return q[18:0];
  endfunction

  function automatic frame_res_t decide_frame(input logic [47:0] now);
    logic [47:0] diff;
    logic [47:0] span;
    logic [47:0] bpos;
    logic        neg;
    logic [8:0]  total;
    longint      thr;
    dec_t        d;
    frame_res_t  r;
    if (last_dec != DEC_IDLE) busy_t = busy_t + now - prev_t;
    diff  = now - win_start;
    neg   = diff[47];
    span  = neg ? -diff : diff;
    total = {1'b0, n_rend} + {1'b0, n_skip};
    if (total >= {1'b0, cfg_wf}) begin
      if (neg) begin
        rrate = '0;
        srate = '0;
        if (n_rend != 0) load_v = '0;
      end else begin
        rrate = 16'(sat_div(128'(n_rend) * cfg_tps * 256, 128'(span), 16, 19'(RATE_MAX)));
        srate = 16'(sat_div(128'(n_skip) * cfg_tps * 256, 128'(span), 16, 19'(RATE_MAX)));
        if (n_rend != 0) begin
          bpos   = busy_t[47] ? 48'd0 : busy_t;
          load_v = sat_div(128'(bpos) * cfg_tr * 65536, 128'(span) * n_rend, 18, LOAD_MAX);
        end
      end
      win_start = now;
      n_rend    = '0;
      n_skip    = '0;
      busy_t    = '0;
      span      = '0;
    end else if (neg) begin
      win_start = now;
      span      = '0;
    end
    prev_t = now;

    thr = longint'(n_rend) * 1310720 + 720896 - 10 * longint'(load_v);
    if (thr > 0 && (128'(span) * cfg_tr * 1310720 < 128'(cfg_tps) * 128'(thr))) begin
      d = DEC_IDLE;
    end else if (skip_run >= cfg_mcs ||
                 128'(span) * cfg_tr < 128'(cfg_tps) * (total + cfg_margin)) begin
      if (n_rend != 8'd255) n_rend++;
      skip_run = '0;
      d = DEC_RENDER;
    end else begin
      if (skip_run != 3'd7) skip_run++;
      if (n_skip != 8'd255) n_skip++;
      d = DEC_SKIP;
    end
    last_dec = d;

    r.decision    = d;
    r.load        = load_v;
    r.render_rate = rrate;
    r.skip_rate   = srate;
    return r;
  endfunction

  always @(posedge clk) begin : tick_drive
    int g;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      g = in_gap;
      if (in_valid && in_ready) begin
        pending_decisions.push_back(decide_frame(now_ticks));
        g = calm ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || in_ready) begin
        if (g > 0) begin
          in_valid <= 1'b0;
          in_gap   <= g - 1;
        end else if (frame_ticks.size() != 0 && !send_pause) begin
          in_valid  <= 1'b1;
          now_ticks <= frame_ticks.pop_front();
          in_gap    <= 0;
        end else begin
          in_valid <= 1'b0;
          in_gap   <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_res_t want;
    int g;
    int h;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
      hold_left <= 0;
    end else begin
      h = hold_go ? HOLD_CYCLES : hold_left;
      g = out_gap;
      if (out_valid && out_ready) begin
        g = calm ? 0 : $urandom_range(0, 3);
        if (pending_decisions.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: dec=%0d load=%0d rr=%0d sr=%0d",
                     decision, load_q16, render_rate_q8, skip_rate_q8);
        end else begin
          want = pending_decisions.pop_front();
          if (decision != want.decision || load_q16 != want.load ||
              render_rate_q8 != want.render_rate || skip_rate_q8 != want.skip_rate) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp dec=%0d load=%0d rr=%0d sr=%0d, got dec=%0d load=%0d rr=%0d sr=%0d",
                       want.decision, want.load, want.render_rate, want.skip_rate,
                       decision, load_q16, render_rate_q8, skip_rate_q8);
          end
        end
      end
      if (h > 0) begin
        out_ready <= 1'b0;
        hold_left <= h - 1;
        out_gap   <= g;
      end else if (g > 0) begin
        out_ready <= 1'b0;
        out_gap   <= g - 1;
        hold_left <= 0;
      end else begin
        out_ready <= 1'b1;
        out_gap   <= 0;
        hold_left <= 0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TPS:    cfg_tps = val;
      REG_TR:     cfg_tr = val[9:0];
      REG_WF:     cfg_wf = val[7:0];
      REG_MARGIN: cfg_margin = val[3:0];
      REG_MCS:    cfg_mcs = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] tps, input logic [9:0] tr, input logic [7:0] wf,
                            input logic [3:0] margin, input logic [2:0] mcs);
    write_reg(REG_TPS, tps);
    write_reg(REG_TR, {22'd0, tr});
    write_reg(REG_WF, {24'd0, wf});
    write_reg(REG_MARGIN, {28'd0, margin});
    write_reg(REG_MCS, {29'd0, mcs});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frame_ticks.size() != 0 || in_valid || pending_decisions.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // mostly paced frames around the nominal period, with bursts, stalls,
  // backward steps and arbitrary timestamps mixed in
  task automatic add_ticks(input int n);
    logic [47:0] period;
    logic [47:0] step;
    int          k;
    int          r;
    period = (cfg_tps == 0) ? 48'd1000 : 48'(cfg_tps / cfg_tr);
    if (period == 0) period = 48'd1;
    for (k = 0; k < n; k++) begin
      step = period * $urandom_range(2, 30) / 10 + $urandom_range(0, 3);
      r = $urandom_range(0, 99);
      if (r < 65) tick_clock = tick_clock + step;
      else if (r < 75) tick_clock = tick_clock + $urandom_range(0, 2);
      else if (r < 83) tick_clock = tick_clock - step * $urandom_range(1, 4);
      else if (r < 93) tick_clock = tick_clock + period * $urandom_range(4, 40);
      else tick_clock = 48'({$urandom, $urandom});
      frame_ticks.push_back(tick_clock);
    end
  endtask

  initial begin : sequencer
    int          ph;
    logic [31:0] tps;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    calm <= 1'b1;

    // all three decisions, backward time, negative busy, time extremes
    set_config(32'd1000, 10'd10, 8'd2, 4'd0, 3'd1);
    frame_ticks = '{48'd0, 48'd0, 48'd150, 48'd150, 48'd150, 48'd400, 48'd250, 48'd260,
                    48'd900, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd5,
                    48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'd3000};
    wait_drained();
    // recompute on every frame, zero span and saturated rates and load
    set_config(32'hFFFF_FFFF, 10'd1000, 8'd0, 4'd0, 3'd1);
    frame_ticks = '{48'd100, 48'd200, 48'd200, 48'd200, 48'd50};
    wait_drained();
    // zero tick rate
    set_config(32'd0, 10'd60, 8'd1, 4'd2, 3'd1);
    frame_ticks = '{48'd10, 48'd20, 48'd30};
    wait_drained();

    tick_clock = '0;
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(32'd1000000, 10'd60, 8'd60, 4'd2, 3'd1);
        1: set_config(32'd1, 10'd1, 8'd1, 4'd0, 3'd0);
        2: set_config(32'hFFFF_FFFF, 10'd1000, 8'd255, 4'd15, 3'd7);
        3: set_config(32'd1000, 10'd1000, 8'd8, 4'd3, 3'd2);
        4: set_config(32'd48000, 10'd30, 8'd4, 4'd1, 3'd3);
        default: begin
          tps = $urandom_range(0, 1) ? $urandom_range(1, 5000) : $urandom;
          if (tps == 0) tps = 32'd1;
          set_config(tps, 10'($urandom_range(1, 1000)), 8'($urandom_range(1, 16)),
                     4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
        end
      endcase
      @(posedge clk);
      calm <= (ph == 4) || ($urandom_range(0, 3) == 0);
      add_ticks(100);
      if (ph == 0) begin
        do @(negedge clk); while (frame_ticks.size() > 90);
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (ph == 3) begin
        do @(negedge clk); while (frame_ticks.size() > 50);
        @(posedge clk);
        send_pause <= 1'b1;
        do @(negedge clk); while (in_valid || pending_decisions.size() != 0);
        @(posedge clk);
        send_pause <= 1'b0;
      end
      add_ticks(100);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
